[src/lcgj_pkg.sv]
package lcgj_pkg;

  // generator constants
  localparam logic [63:0] LcgMul = 64'd6364136223846793005;
  localparam logic [63:0] LcgAdd = 64'd1;

  localparam int unsigned SeedW   = 64;
  localparam int unsigned ScaleW  = 32;
  localparam int unsigned ShiftW  = 32;
  localparam int unsigned StrideW = 32;
  localparam int unsigned LenW    = 25;
  localparam int unsigned ColW    = 16;
  localparam int unsigned RowW    = 32;
  localparam int unsigned CfgIdxW = 3;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_SEED          = 3'd0,
    CFG_SCALE         = 3'd1,
    CFG_COMPLEX_MODE  = 3'd2,
    CFG_START_SHIFT   = 3'd3,
    CFG_COLUMN_STRIDE = 3'd4,
    CFG_COLUMN_LENGTH = 3'd5
  } cfg_idx_e;

  // input command codes
  typedef enum logic {
    CMD_SEEK = 1'b0,
    CMD_DRAW = 1'b1
  } cmd_e;

  // operations of the shared multiply unit
  typedef enum logic {
    MAC_SINGLE = 1'b0,  // c + a[32:0] * b[32:0], signed, one partial product
    MAC_FULL   = 1'b1   // c + a * b mod 2^64, three partial products
  } mac_op_e;

  typedef struct packed {
    logic    start;
    mac_op_e op;
  } mac_req_t;

  // 2^31 - hi as a sign-extended 64-bit operand
  function automatic logic [63:0] center_ext(logic [31:0] hi);
    logic signed [32:0] c;
    c = $signed({1'b0, 32'h8000_0000}) - $signed({1'b0, hi});
    return {{31{c[32]}}, c};
  endfunction

endpackage

[src/lcgj_mac.sv]
module lcgj_mac import lcgj_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  mac_req_t    req_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  input  logic [63:0] c_i,
  output logic [63:0] res_o,
  output logic        done_o
);

  logic [63:0] a_q, b_q, c_q;
  mac_op_e     op_q;
  logic [1:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [63:0] prod_q, prod_d;
  logic [63:0] acc_q, acc_d;
  logic [1:0]  last_cnt;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_full;

  assign last_cnt = (op_q == MAC_FULL) ? 2'd3 : 2'd1;

  // operand halves for each partial product
  always_comb begin
    mul_a = {1'b0, a_q[31:0]};
    mul_b = {1'b0, b_q[31:0]};
    case (cnt_q)
      2'd0: begin
        if (op_q == MAC_SINGLE) begin
          mul_a = a_q[32:0];
          mul_b = b_q[32:0];
        end
      end
      2'd1: mul_b = {1'b0, b_q[63:32]};
      2'd2: mul_a = {1'b0, a_q[63:32]};
      default: ;
    endcase
  end

  // the one shared multiplier
  assign mul_full = mul_a * mul_b;
  assign prod_d   = mul_full[63:0];

  // accumulate the previous partial product
  always_comb begin
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (busy_q) begin
      if (cnt_q == 2'd1) begin
        acc_d = c_q + prod_q;
      end else if (cnt_q != 2'd0) begin
        acc_d = acc_q + {prod_q[31:0], 32'h0};
      end
      if (cnt_q == last_cnt) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q + 2'd1;
      end
    end
    if (req_i.start) begin
      cnt_d  = 2'd0;
      busy_d = 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= 2'd0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // operands and datapath
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q  <= a_i;
      b_q  <= b_i;
      c_q  <= c_i;
      op_q <= req_i.op;
    end
    prod_q <= prod_d;
    acc_q  <= acc_d;
  end

  assign res_o  = acc_q;
  assign done_o = done_q;

endmodule

[src/lcg_jump_random_vector_gen_unit.sv]
// channel | dir | tdata (low bit up)               | tuser | tlast
// s_axis  | in  | column[15:0], row[47:16]         | cmd   | -
// m_axis  | out | raw_value[63:0], real_part[95:64],| -     | last_in_column
//         |     | imag_part[127:96]                |       |
// cfg     | in  | cfg_we_i, cfg_idx_i, cfg_data_i (write only)
//
// one item at a time; a 64-bit multiply takes three partial products on the shared multiplier,
// a scaling multiply one
// draw: scale real part, advance; in complex mode scale imag part, advance again;
// then wait for the output register. seek: two multiplies per bit up to the highest
// set bit of the position, one more per set bit; the position stays under 2^50
// reset clears the generator state and draw count and loads register defaults
// a stalled result holds the last stage; the next item is taken meanwhile
module lcg_jump_random_vector_gen_unit import lcgj_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  // configuration
  input  logic           cfg_we_i,
  input  logic [2:0]     cfg_idx_i,
  input  logic [63:0]    cfg_data_i,
  // input stream
  input  logic           s_axis_tvalid,
  output logic           s_axis_tready,
  input  logic [47:0]    s_axis_tdata,   // column[15:0], row[47:16]
  input  logic           s_axis_tuser,   // cmd[0]
  // output stream
  output logic           m_axis_tvalid,
  input  logic           m_axis_tready,
  output logic [127:0]   m_axis_tdata,   // raw_value[63:0], real[95:64], imag[127:96]
  output logic           m_axis_tlast    // last_in_column
);

  typedef enum logic [12:0] {
    ST_IDLE    = 13'b0000000000001,
    ST_POS_W   = 13'b0000000000010,
    ST_JBIT    = 13'b0000000000100,
    ST_JX_W    = 13'b0000000001000,
    ST_JA_W    = 13'b0000000010000,
    ST_JM_W    = 13'b0000000100000,
    ST_DRE_W   = 13'b0000001000000,
    ST_DADV_W  = 13'b0000010000000,
    ST_DIM_W   = 13'b0000100000000,
    ST_DADV2_W = 13'b0001000000000,
    ST_EMIT    = 13'b0010000000000,
    ST_JSTART  = 13'b0100000000000,
    ST_SPARE   = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [SeedW-1:0]   seed_q;
  logic [ScaleW-1:0]  scale_q;
  logic               complex_q;
  logic [ShiftW-1:0]  shift_q;
  logic [StrideW-1:0] stride_q;
  logic [LenW-1:0]    len_q;

  // generator state
  logic [63:0]     cur_q, cur_d;
  logic [LenW-1:0] cnt_q, cnt_d;

  // jump-ahead registers
  logic [63:0] steps_q, steps_d;
  logic [63:0] jmul_q, jmul_d;
  logic [63:0] jadd_q, jadd_d;
  logic [63:0] x_q, x_d;

  // output registers
  logic               out_valid_q, out_valid_d;
  logic [63:0]        raw_q, raw_d;
  logic signed [31:0] re_q, re_d;
  logic signed [31:0] im_q, im_d;
  logic [31:0]        out_re_q, out_im_q;
  logic [63:0]        out_raw_q;
  logic               out_last_q;

  logic               load_out;
  logic [LenW-1:0]    cnt_inc, len_eff;
  logic               last_hit;

  // shared multiply unit
  mac_req_t    mac_req;
  logic [63:0] mac_a, mac_b, mac_c, mac_res;
  logic        mac_done;

  logic s_acc;
  logic [ColW-1:0] in_col;
  logic [RowW-1:0] in_row;

  assign in_col = s_axis_tdata[ColW-1:0];
  assign in_row = s_axis_tdata[ColW+RowW-1:ColW];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  lcgj_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mac_req),
    .a_i    (mac_a),
    .b_i    (mac_b),
    .c_i    (mac_c),
    .res_o  (mac_res),
    .done_o (mac_done)
  );

  // column bookkeeping
  assign cnt_inc  = cnt_q + 1'b1;
  assign len_eff  = (len_q == '0) ? LenW'(1) : len_q;
  assign last_hit = (cnt_inc == len_eff);
  assign load_out = (state_q == ST_EMIT) && (!out_valid_q || m_axis_tready);

  // sequencer
  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    cnt_d       = cnt_q;
    steps_d     = steps_q;
    jmul_d      = jmul_q;
    jadd_d      = jadd_q;
    x_d         = x_q;
    raw_d       = raw_q;
    re_d        = re_q;
    im_d        = im_q;
    mac_req     = '{start: 1'b0, op: MAC_FULL};
    mac_a       = jmul_q;
    mac_b       = x_q;
    mac_c       = jadd_q;
    out_valid_d = out_valid_q && !m_axis_tready;

    unique case (state_q)
      ST_IDLE: begin
        if (s_acc) begin
          if (s_axis_tuser == CMD_SEEK) begin
            // column * stride + shift + row
            mac_req = '{start: 1'b1, op: MAC_SINGLE};
            mac_a   = {48'h0, in_col};
            mac_b   = {32'h0, stride_q};
            mac_c   = {32'h0, shift_q} + {32'h0, in_row};
            state_d = ST_POS_W;
          end else begin
            raw_d   = cur_q;
            mac_req = '{start: 1'b1, op: MAC_SINGLE};
            mac_a   = center_ext(cur_q[63:32]);
            mac_b   = {{32{scale_q[31]}}, scale_q};
            mac_c   = '0;
            state_d = ST_DRE_W;
          end
        end
      end
      ST_POS_W: begin
        if (mac_done) begin
          steps_d = complex_q ? {mac_res[62:0], 1'b0} : mac_res;
          jmul_d  = LcgMul;
          jadd_d  = LcgAdd;
          x_d     = seed_q;
          state_d = ST_JSTART;
        end
      end
      ST_JSTART: begin
        if (steps_q == '0) begin
          cur_d   = x_q;
          cnt_d   = '0;
          state_d = ST_IDLE;
        end else begin
          state_d = ST_JBIT;
        end
      end
      ST_JBIT: begin
        mac_req = '{start: 1'b1, op: MAC_FULL};
        if (steps_q[0]) begin
          // x = mul * x + add
          state_d = ST_JX_W;
        end else begin
          // add = add * (mul + 1)
          mac_a   = jadd_q;
          mac_b   = jmul_q + 64'd1;
          mac_c   = '0;
          state_d = ST_JA_W;
        end
      end
      ST_JX_W: begin
        if (mac_done) begin
          x_d     = mac_res;
          mac_req = '{start: 1'b1, op: MAC_FULL};
          mac_a   = jadd_q;
          mac_b   = jmul_q + 64'd1;
          mac_c   = '0;
          state_d = ST_JA_W;
        end
      end
      ST_JA_W: begin
        if (mac_done) begin
          // mul = mul * mul
          jadd_d  = mac_res;
          mac_req = '{start: 1'b1, op: MAC_FULL};
          mac_a   = jmul_q;
          mac_b   = jmul_q;
          mac_c   = '0;
          state_d = ST_JM_W;
        end
      end
      ST_JM_W: begin
        if (mac_done) begin
          jmul_d  = mac_res;
          steps_d = {1'b0, steps_q[63:1]};
          state_d = ST_JSTART;
        end
      end
      ST_DRE_W: begin
        if (mac_done) begin
          re_d    = mac_res[63:32];
          mac_req = '{start: 1'b1, op: MAC_FULL};
          mac_a   = LcgMul;
          mac_b   = cur_q;
          mac_c   = LcgAdd;
          state_d = ST_DADV_W;
        end
      end
      ST_DADV_W: begin
        if (mac_done) begin
          cur_d = mac_res;
          if (complex_q) begin
            mac_req = '{start: 1'b1, op: MAC_SINGLE};
            mac_a   = center_ext(mac_res[63:32]);
            mac_b   = {{32{scale_q[31]}}, scale_q};
            mac_c   = '0;
            state_d = ST_DIM_W;
          end else begin
            im_d    = '0;
            state_d = ST_EMIT;
          end
        end
      end
      ST_DIM_W: begin
        if (mac_done) begin
          im_d    = mac_res[63:32];
          mac_req = '{start: 1'b1, op: MAC_FULL};
          mac_a   = LcgMul;
          mac_b   = cur_q;
          mac_c   = LcgAdd;
          state_d = ST_DADV2_W;
        end
      end
      ST_DADV2_W: begin
        if (mac_done) begin
          cur_d   = mac_res;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (load_out) begin
          out_valid_d = 1'b1;
          cnt_d       = last_hit ? '0 : cnt_inc;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control and generator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cur_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_q       <= cur_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q    <= '0;
      scale_q   <= 32'd65536;
      complex_q <= 1'b0;
      shift_q   <= 32'd1;
      stride_q  <= '0;
      len_q     <= LenW'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SEED:          seed_q    <= cfg_data_i;
        CFG_SCALE:         scale_q   <= cfg_data_i[ScaleW-1:0];
        CFG_COMPLEX_MODE:  complex_q <= cfg_data_i[0];
        CFG_START_SHIFT:   shift_q   <= cfg_data_i[ShiftW-1:0];
        CFG_COLUMN_STRIDE: stride_q  <= cfg_data_i[StrideW-1:0];
        CFG_COLUMN_LENGTH: len_q     <= cfg_data_i[LenW-1:0];
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    steps_q <= steps_d;
    jmul_q  <= jmul_d;
    jadd_q  <= jadd_d;
    x_q     <= x_d;
    raw_q   <= raw_d;
    re_q    <= re_d;
    im_q    <= im_d;
    if (load_out) begin
      out_raw_q  <= raw_q;
      out_re_q   <= re_q;
      out_im_q   <= im_q;
      out_last_q <= last_hit;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_im_q, out_re_q, out_raw_q};
  assign m_axis_tlast  = out_last_q;

endmodule

[src/lcgj_checker.sv]
module lcgj_checker import lcgj_pkg::*; (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         s_axis_tuser,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [127:0] m_axis_tdata,
  input logic         m_axis_tlast
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // one item at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while busy");

  // a draw result does not rise straight after its input is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tvalid && s_axis_tready))
    else $error("result too early");

  // a seek transaction gives no result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_SEEK) |=>
      !$rose(m_axis_tvalid))
    else $error("seek produced a result");

endmodule

bind lcg_jump_random_vector_gen_unit lcgj_checker u_lcgj_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

[dv/lcg_jump_random_vector_gen_unit_tb.sv]
module lcg_jump_random_vector_gen_unit_tb;
  import lcgj_pkg::*;

  // generator step, kept separate from the design package
  localparam logic [63:0] StepMul = 64'd6364136223846793005;
  localparam logic [63:0] StepAdd = 64'd1;
  // this outlasts the longest seek, so it covers a seek with no result
  localparam int unsigned SettleCycles = 1100;
  localparam int unsigned DrainLimit   = 200000;

  typedef struct {
    logic [63:0] raw;
    logic [31:0] re;
    logic [31:0] im;
    logic        last;
  } draw_result_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [2:0]   cfg_idx_i = '0;
  logic [63:0]  cfg_data_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [47:0]  s_axis_tdata = '0;   // column[15:0], row[47:16]
  logic         s_axis_tuser = 1'b0; // cmd[0]
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;        // raw_value[63:0], real_part[95:64], imag_part[127:96]
  logic         m_axis_tlast;        // last_in_column

  // register shadows, reset values
  logic [63:0] seed_reg    = '0;
  logic [31:0] scale_reg   = 32'd65536;
  logic        complex_reg = 1'b0;
  logic [31:0] shift_reg   = 32'd1;
  logic [31:0] stride_reg  = '0;
  logic [24:0] length_reg  = 25'd1;

  // generator state mirror
  logic [63:0] gen_state  = '0;
  logic [24:0] draw_count = '0;

  draw_result_t expected_draws[$];
  int fail_count    = 0;
  int tx_idle_pct   = 0;
  int rx_stall_pct  = 0;
  int rx_hold_count = 0;

  lcg_jump_random_vector_gen_unit uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    #120_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // advance a generator value by an arbitrary number of steps
  function automatic logic [63:0] jump_ahead(logic [63:0] x, logic [63:0] steps);
    logic [63:0] mul_k;
    logic [63:0] add_k;
    mul_k = StepMul;
    add_k = StepAdd;
    for (int b = 0; b < 64; b++) begin
      if (steps[b]) x = mul_k * x + add_k;
      add_k = add_k * (mul_k + 64'd1);
      mul_k = mul_k * mul_k;
    end
    return x;
  endfunction

  // (2^31 - hi) * scale, floored shift by 32
  function automatic logic [31:0] q16_scaled(logic [63:0] x);
    longint centered;
    longint factor;
    longint prod;
    centered = 64'sd2147483648 - longint'({32'd0, x[63:32]});
    factor   = longint'($signed(scale_reg));
    prod     = centered * factor;
    return prod[63:32];
  endfunction

  // update the generator mirror for one accepted transaction
  function automatic void apply_item(cmd_e cmd, logic [15:0] col, logic [31:0] row);
    logic [63:0]  pos;
    logic [24:0]  len_eff;
    draw_result_t res;
    if (cmd == CMD_SEEK) begin
      pos = {32'd0, shift_reg} + {48'd0, col} * {32'd0, stride_reg} + {32'd0, row};
      if (complex_reg) pos = pos << 1;
      gen_state  = jump_ahead(seed_reg, pos);
      draw_count = '0;
    end else begin
      len_eff   = (length_reg == '0) ? 25'd1 : length_reg;
      res.raw   = gen_state;
      res.re    = q16_scaled(gen_state);
      res.im    = '0;
      gen_state = StepMul * gen_state + StepAdd;
      if (complex_reg) begin
        res.im    = q16_scaled(gen_state);
        gen_state = StepMul * gen_state + StepAdd;
      end
      draw_count = draw_count + 25'd1;
      res.last   = (draw_count == len_eff);
      if (res.last) draw_count = '0;
      expected_draws.push_back(res);
    end
  endfunction

  // receiver: random stalls plus an optional long hold-off
  initial begin
    forever begin
      @(posedge clk_i);
      if (rx_hold_count > 0) begin
        rx_hold_count--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    draw_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_draws.size() == 0) begin
        $error("unexpected result transaction, raw_value %h", m_axis_tdata[63:0]);
        fail_count++;
      end else begin
        want = expected_draws.pop_front();
        if (m_axis_tdata[63:0] !== want.raw) begin
          $error("raw_value expected %h got %h", want.raw, m_axis_tdata[63:0]);
          fail_count++;
        end
        if (m_axis_tdata[95:64] !== want.re) begin
          $error("real_part expected %h got %h", want.re, m_axis_tdata[95:64]);
          fail_count++;
        end
        if (m_axis_tdata[127:96] !== want.im) begin
          $error("imag_part expected %h got %h", want.im, m_axis_tdata[127:96]);
          fail_count++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last_in_column expected %b got %b", want.last, m_axis_tlast);
          fail_count++;
        end
      end
    end
  end

  // one command transaction on the input stream
  task automatic send_item(cmd_e cmd, logic [15:0] col, logic [31:0] row);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {row, col};
    do @(posedge clk_i); while (!s_axis_tready);
    apply_item(cmd, col, row);
  endtask

  // drop valid, collect every pending draw, then let a running seek finish
  task automatic wait_idle();
    int n;
    n = 0;
    s_axis_tvalid <= 1'b0;
    while (expected_draws.size() > 0 && n < DrainLimit) begin
      @(posedge clk_i);
      n++;
    end
    if (expected_draws.size() > 0) begin
      $error("%0d draws never returned", expected_draws.size());
      fail_count++;
      expected_draws.delete();
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [63:0] val);
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    cfg_we_i   <= 1'b1;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_SEED:          seed_reg    = val;
      CFG_SCALE:         scale_reg   = val[31:0];
      CFG_COMPLEX_MODE:  complex_reg = val[0];
      CFG_START_SHIFT:   shift_reg   = val[31:0];
      CFG_COLUMN_STRIDE: stride_reg  = val[31:0];
      CFG_COLUMN_LENGTH: length_reg  = val[24:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic write_all_regs(logic [63:0] seed, logic [31:0] scale, logic cplx,
                                logic [31:0] shift, logic [31:0] stride, logic [24:0] len);
    write_reg(CFG_SEED, seed);
    write_reg(CFG_SCALE, {32'd0, scale});
    write_reg(CFG_COMPLEX_MODE, {63'd0, cplx});
    write_reg(CFG_START_SHIFT, {32'd0, shift});
    write_reg(CFG_COLUMN_STRIDE, {32'd0, stride});
    write_reg(CFG_COLUMN_LENGTH, {39'd0, len});
  endtask

  // reset defaults: draws before any seek, then a seek to the default shift
  task automatic test_reset_defaults();
    send_item(CMD_DRAW, 16'hffff, 32'hffff_ffff);
    send_item(CMD_DRAW, 16'h0, 32'h0);
    send_item(CMD_SEEK, 16'h0, 32'h0);
    send_item(CMD_DRAW, 16'h0, 32'h0);
    send_item(CMD_DRAW, 16'h0, 32'h0);
  endtask

  // field and register extremes
  task automatic test_extremes();
    // zero length, seek to the seed itself, most negative scale
    wait_idle();
    write_all_regs('1, 32'h8000_0000, 1'b0, 32'h0, 32'hffff_ffff, 25'd0);
    send_item(CMD_SEEK, 16'h0, 32'h0);
    send_item(CMD_DRAW, 16'h0, 32'h0);
    send_item(CMD_DRAW, 16'h0, 32'h0);
    send_item(CMD_SEEK, 16'hffff, 32'hffff_ffff);
    send_item(CMD_DRAW, 16'h0, 32'h0);
    // complex mode, largest position doubled, draws across a column end
    wait_idle();
    write_all_regs('0, 32'h7fff_ffff, 1'b1, 32'hffff_ffff, 32'hffff_ffff, 25'd2);
    send_item(CMD_SEEK, 16'hffff, 32'hffff_ffff);
    send_item(CMD_DRAW, 16'h0, 32'h0);
    send_item(CMD_DRAW, 16'h0, 32'h0);
    send_item(CMD_DRAW, 16'h0, 32'h0);
    wait_idle();
    write_reg(CFG_START_SHIFT, 64'd0);
    write_reg(CFG_COLUMN_STRIDE, 64'd0);
    send_item(CMD_SEEK, 16'h0, 32'h0);
    send_item(CMD_DRAW, 16'h0, 32'h0);
    // zero scale, a column length of 2^24
    wait_idle();
    write_all_regs(64'h0123_4567_89ab_cdef, 32'h0, 1'b0, 32'd7, 32'd3, 25'd16777216);
    send_item(CMD_SEEK, 16'd1, 32'd5);
    send_item(CMD_DRAW, 16'h0, 32'h0);
    send_item(CMD_DRAW, 16'h0, 32'h0);
  endtask

  function automatic logic [24:0] pick_length();
    int r;
    r = $urandom_range(19);
    if (r == 0) return 25'd0;
    if (r == 1) return 25'd16777216;
    return 25'($urandom_range(1, 8));
  endfunction

  // mostly seeks followed by a run of draws, with some stray commands
  task automatic run_random_phase(int n_items, int tx_pct, int rx_pct);
    int sent;
    int n_draws;
    int len_cap;
    logic [15:0] col;
    logic [31:0] row;
    wait_idle();
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    write_all_regs({$urandom, $urandom}, $urandom, 1'($urandom_range(1)),
                   $urandom, $urandom, pick_length());
    len_cap = (length_reg == '0) ? 1 : ((length_reg > 8) ? 8 : int'(length_reg));
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 8) begin
        send_item(cmd_e'($urandom_range(1)), 16'($urandom), $urandom);
        sent++;
      end else begin
        if ($urandom_range(1)) begin
          col = 16'($urandom);
          row = $urandom;
        end else begin
          col = 16'($urandom_range(3));
          row = $urandom_range(255);
        end
        send_item(CMD_SEEK, col, row);
        sent++;
        n_draws = $urandom_range(1, len_cap + 2);
        repeat (n_draws) begin
          send_item(CMD_DRAW, 16'($urandom), $urandom);
          sent++;
        end
      end
    end
  endtask

  // long receiver hold-off while draws keep coming, so the input stalls
  task automatic test_backpressure();
    wait_idle();
    tx_idle_pct   = 0;
    rx_stall_pct  = 0;
    write_all_regs({$urandom, $urandom}, $urandom, 1'b1, $urandom, $urandom, 25'd5);
    send_item(CMD_SEEK, 16'($urandom), $urandom);
    rx_hold_count = 400;
    repeat (30) send_item(CMD_DRAW, 16'($urandom), $urandom);
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_defaults();
    test_extremes();
    run_random_phase(445, 0, 0);
    test_backpressure();
    run_random_phase(445, 81, 0);
    run_random_phase(445, 0, 81);
    run_random_phase(445, 23, 23);
    wait_idle();
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
src/lcgj_pkg.sv
src/lcgj_mac.sv
src/lcg_jump_random_vector_gen_unit.sv
src/lcgj_checker.sv
dv/lcg_jump_random_vector_gen_unit_tb.sv
